// ===== hw/rtl/bvt_pkg.sv =====
package bvt_pkg;

	localparam int DEPTH     = 16;
	localparam int WORD_BITS = 32;
	localparam int IDX_BITS  = $clog2(DEPTH);
	localparam int CNT_BITS  = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		MODE_READ       = 3'd0,
		MODE_WRITE      = 3'd1,
		MODE_INSERT     = 3'd2,
		MODE_SEARCH     = 3'd3,
		MODE_RESIZE     = 3'd4,
		MODE_FILL_VALUE = 3'd5,
		MODE_FILL_INDEX = 3'd6
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ_WAIT,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_ZERO_WR,
		ST_FILL_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                 we;
		logic [IDX_BITS-1:0]  waddr;
		logic [WORD_BITS-1:0] wdata;
		logic [IDX_BITS-1:0]  raddr;
	} mem_req_t;

	typedef struct packed {
		logic                 ok;
		logic                 found;
		logic [IDX_BITS-1:0]  found_index;
		logic [WORD_BITS-1:0] read_value;
		logic [CNT_BITS-1:0]  element_count;
	} result_t;

endpackage

// ===== hw/rtl/bounded_vector_table_unit.sv =====
// Bounded ordered table of 16 words with a live element count. Each input item
// carries a mode (read, write, insert, search, resize, fill with value, fill
// with index numbers) and its operands, and yields exactly one result item
// with ok, search hit and first index, read word and the count after the
// operation. The block works on one item at a time: a small sequencer walks
// a table with separate write and read ports (one write and one registered
// read per cycle) with one shared index compare, and in_stall stays high
// until the result has moved into the output register. A finished result
// waits in the output register while the next item is accepted.
// Table entries come up undefined after reset; reading one that was never
// written returns an undefined word. The count resets to zero.
module bounded_vector_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [4:0]  position,
	input  logic [31:0] value,
	input  logic [4:0]  length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic        found,
	output logic [3:0]  found_index,
	output logic [31:0] read_value,
	output logic [4:0]  element_count
);
	import bvt_pkg::*;

	mem_req_t             mem_req;
	logic [WORD_BITS-1:0] rd_data;
	result_t              res;
	logic                 res_valid;
	logic                 res_take;
	result_t              out_q;
	logic                 out_valid_q;

	// sequencer: owns the count and the walk index
	bvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.position  (position),
		.value     (value),
		.length    (length),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.mem_req   (mem_req),
		.rd_data   (rd_data)
	);

	// word storage, registered read
	bvt_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	// take a new result when the output register is empty or being drained
	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the payload while stalled
	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign ok            = out_q.ok;
	assign found         = out_q.found;
	assign found_index   = out_q.found_index;
	assign read_value    = out_q.read_value;
	assign element_count = out_q.element_count;

endmodule

// ===== hw/rtl/bvt_mem.sv =====
module bvt_mem (
	input  logic                          clk,
	input  bvt_pkg::mem_req_t             req,
	output logic [bvt_pkg::WORD_BITS-1:0] rd_data
);
	import bvt_pkg::*;

	logic [WORD_BITS-1:0] mem_q [DEPTH];
	logic [WORD_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rd_data_q <= mem_q[req.raddr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/bvt_ctrl.sv =====
module bvt_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    mode,
	input  logic [4:0]                    position,
	input  logic [31:0]                   value,
	input  logic [4:0]                    length,
	output logic                          res_valid,
	input  logic                          res_take,
	output bvt_pkg::result_t              res,
	output bvt_pkg::mem_req_t             mem_req,
	input  logic [bvt_pkg::WORD_BITS-1:0] rd_data
);
	import bvt_pkg::*;

	state_t               state_q, state_d;
	logic [CNT_BITS-1:0]  idx_q, idx_d;
	logic [CNT_BITS-1:0]  count_q, count_d;
	mode_t                mode_q, mode_d;
	logic [CNT_BITS-1:0]  pos_q, pos_d;
	logic [CNT_BITS-1:0]  len_q, len_d;
	logic [WORD_BITS-1:0] val_q, val_d;
	result_t              res_q, res_d;

	// shared index compare: walk counter against the active bound
	logic [CNT_BITS-1:0]  bound;
	logic                 idx_below;
	logic [CNT_BITS-1:0]  limit;

	assign limit = CNT_BITS'(DEPTH);

	always_comb begin
		unique case (state_q)
			ST_SHIFT_RD: bound = pos_q;
			ST_SRCH_RD:  bound = count_q;
			default:     bound = len_q;
		endcase
	end

	// in the shift loop the test is idx > pos, elsewhere idx < bound
	assign idx_below = (state_q == ST_SHIFT_RD) ? (bound < idx_q) : (idx_q < bound);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		mode_q <= mode_d;
		pos_q  <= pos_d;
		len_q  <= len_d;
		val_q  <= val_d;
		res_q  <= res_d;
	end

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		count_d   = count_q;
		mode_d    = mode_q;
		pos_d     = pos_q;
		len_d     = len_q;
		val_d     = val_q;
		res_d     = res_q;
		mem_req   = '0;
		in_stall  = 1'b1;
		res_valid = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				in_stall      = 1'b0;
				mem_req.raddr = position[IDX_BITS-1:0];
				if (in_valid) begin
					mode_d = mode_t'(mode);
					pos_d  = position;
					len_d  = length;
					val_d  = value[WORD_BITS-1:0];
					res_d  = '0;
					state_d = ST_DONE;
					unique case (mode_t'(mode))
						MODE_READ: begin
							if (position < limit) begin
								state_d = ST_READ_WAIT;
							end
						end
						MODE_WRITE: begin
							if (position < limit) begin
								mem_req.we    = 1'b1;
								mem_req.waddr = position[IDX_BITS-1:0];
								mem_req.wdata = value[WORD_BITS-1:0];
								res_d.ok      = 1'b1;
							end
						end
						MODE_INSERT: begin
							if (position <= count_q && count_q < limit) begin
								idx_d   = count_q;
								state_d = ST_SHIFT_RD;
							end
						end
						MODE_SEARCH: begin
							idx_d   = '0;
							state_d = ST_SRCH_RD;
						end
						MODE_RESIZE: begin
							if (length <= limit) begin
								idx_d   = count_q;
								state_d = ST_ZERO_WR;
							end
						end
						MODE_FILL_VALUE, MODE_FILL_INDEX: begin
							if (length <= limit) begin
								idx_d   = '0;
								state_d = ST_FILL_WR;
							end
						end
						default: begin
							// unused mode: refuse, ok stays low
						end
					endcase
				end
			end

			ST_READ_WAIT: begin
				res_d.ok         = 1'b1;
				res_d.read_value = rd_data;
				state_d          = ST_DONE;
			end

			ST_SHIFT_RD: begin
				if (idx_below) begin
					mem_req.raddr = IDX_BITS'(idx_q - 1'b1);
					state_d       = ST_SHIFT_WR;
				end else begin
					mem_req.we    = 1'b1;
					mem_req.waddr = pos_q[IDX_BITS-1:0];
					mem_req.wdata = val_q;
					count_d       = count_q + 1'b1;
					res_d.ok      = 1'b1;
					state_d       = ST_DONE;
				end
			end

			ST_SHIFT_WR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = idx_q[IDX_BITS-1:0];
				mem_req.wdata = rd_data;
				idx_d         = idx_q - 1'b1;
				state_d       = ST_SHIFT_RD;
			end

			ST_SRCH_RD: begin
				if (idx_below) begin
					mem_req.raddr = idx_q[IDX_BITS-1:0];
					state_d       = ST_SRCH_CMP;
				end else begin
					res_d.ok = 1'b1;
					state_d  = ST_DONE;
				end
			end

			ST_SRCH_CMP: begin
				if (rd_data == val_q) begin
					res_d.ok          = 1'b1;
					res_d.found       = 1'b1;
					res_d.found_index = idx_q[IDX_BITS-1:0];
					state_d           = ST_DONE;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = ST_SRCH_RD;
				end
			end

			ST_ZERO_WR, ST_FILL_WR: begin
				if (idx_below) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = idx_q[IDX_BITS-1:0];
					if (state_q == ST_ZERO_WR) begin
						mem_req.wdata = '0;
					end else if (mode_q == MODE_FILL_VALUE) begin
						mem_req.wdata = val_q;
					end else begin
						mem_req.wdata = WORD_BITS'(idx_q);
					end
					idx_d = idx_q + 1'b1;
				end else begin
					count_d  = len_q;
					res_d.ok = 1'b1;
					state_d  = ST_DONE;
				end
			end

			ST_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		res               = res_q;
		res.element_count = count_q;
	end

endmodule

// ===== verif/tb_bounded_vector_table_unit.sv =====
`timescale 1ns / 1ps

module tb_bounded_vector_table_unit;
	import bvt_pkg::*;

	// Mode value with no operation behind it; the block must refuse it.
	localparam logic [2:0] MODE_UNUSED = 3'd7;

	localparam int RANDOM_ITEMS    = 1950;
	// Result number at which the receiver holds off for a long stretch.
	localparam int BACKLOG_AT      = 300;
	localparam int BACKLOG_CYCLES  = 300;
	// Longest walk is a search over a full table, then the output register.
	localparam int DRAIN_CYCLES    = 50;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  mode;
	logic [4:0]  position;
	logic [31:0] value;
	logic [4:0]  length;
	logic        out_valid;
	logic        out_stall;
	logic        ok;
	logic        found;
	logic [3:0]  found_index;
	logic [31:0] read_value;
	logic [4:0]  element_count;

	bounded_vector_table_unit dut (.*);

	// One row of the directed table. Rows with typed set carry a result that
	// is obvious from the operation alone; the rest are checked against the
	// table predictor.
	typedef struct {
		logic [2:0]  op;
		logic [4:0]  pos;
		logic [31:0] word;
		logic [4:0]  len;
		bit          typed;
		result_t     want;
	} stim_row_t;

	// Shadow copy of the table: words, which entries hold a written word,
	// and the live count.
	logic [31:0] table_words [DEPTH];
	bit          table_written [DEPTH];
	int          live_count;

	result_t     pending_results [$];
	int          mismatches;
	bit          tx_quiet;
	bit          rx_quiet;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop for a hung handshake.
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	// Apply one item to the shadow table and return the result it must produce.
	function automatic result_t table_apply(logic [2:0] m, logic [4:0] p, logic [31:0] v,
			logic [4:0] l);
		result_t r;
		int      i;
		r = '0;
		case (m)
			MODE_READ: begin
				if (p < DEPTH) begin
					r.ok         = 1'b1;
					r.read_value = table_words[p];
				end
			end
			MODE_WRITE: begin
				if (p < DEPTH) begin
					table_words[p]   = v;
					table_written[p] = 1'b1;
					r.ok             = 1'b1;
				end
			end
			MODE_INSERT: begin
				// Shift the tail up by one, then drop the word into the gap.
				if (p <= live_count && live_count < DEPTH) begin
					for (i = live_count; i > p; i--)
						table_words[i] = table_words[i - 1];
					table_words[p]            = v;
					table_written[live_count] = 1'b1;
					live_count++;
					r.ok = 1'b1;
				end
			end
			MODE_SEARCH: begin
				// Walk down so the lowest matching index wins.
				r.ok = 1'b1;
				for (i = live_count - 1; i >= 0; i--) begin
					if (table_words[i] == v) begin
						r.found       = 1'b1;
						r.found_index = i[3:0];
					end
				end
			end
			MODE_RESIZE: begin
				// Zero the new entries when growing; shrinking only moves the count.
				if (l <= DEPTH) begin
					for (i = live_count; i < l; i++) begin
						table_words[i]   = '0;
						table_written[i] = 1'b1;
					end
					live_count = l;
					r.ok       = 1'b1;
				end
			end
			MODE_FILL_VALUE, MODE_FILL_INDEX: begin
				if (l <= DEPTH) begin
					for (i = 0; i < l; i++) begin
						table_words[i]   = (m == MODE_FILL_VALUE) ? v : 32'(i);
						table_written[i] = 1'b1;
					end
					live_count = l;
					r.ok       = 1'b1;
				end
			end
			default: ;
		endcase
		r.element_count = live_count[4:0];
		return r;
	endfunction

	function automatic stim_row_t op_row(logic [2:0] m, logic [4:0] p, logic [31:0] v,
			logic [4:0] l);
		stim_row_t r;
		r.op    = m;
		r.pos   = p;
		r.word  = v;
		r.len   = l;
		r.typed = 1'b0;
		r.want  = '0;
		return r;
	endfunction

	function automatic stim_row_t op_row_exp(logic [2:0] m, logic [4:0] p, logic [31:0] v,
			logic [4:0] l, logic ok_e, logic found_e, logic [3:0] idx_e, logic [31:0] rd_e,
			logic [4:0] cnt_e);
		stim_row_t r;
		r                    = op_row(m, p, v, l);
		r.typed              = 1'b1;
		r.want.ok            = ok_e;
		r.want.found         = found_e;
		r.want.found_index   = idx_e;
		r.want.read_value    = rd_e;
		r.want.element_count = cnt_e;
		return r;
	endfunction

	// Offer one item after a random gap, hold it until it is taken, then
	// advance the shadow table and queue the result it must produce.
	task automatic send_item(input logic [2:0] m, input logic [4:0] p, input logic [31:0] v,
			input logic [4:0] l, input bit typed, input result_t want);
		int      gap;
		result_t predicted;
		if ($urandom_range(0, 63) == 0)
			tx_quiet = !tx_quiet;
		gap = tx_quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		position <= p;
		value    <= v;
		length   <= l;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		predicted = table_apply(m, p, v, l);
		if (typed)
			predicted = want;
		pending_results = {pending_results, predicted};
	endtask

	// Draw one random item. Most items are well formed against the current
	// count; a few carry out-of-range positions and lengths or the unused mode.
	task automatic pick_random_item(output logic [2:0] m, output logic [4:0] p,
			output logic [31:0] v, output logic [4:0] l);
		int sel;
		int k;
		sel = $urandom_range(0, 99);
		p   = $urandom_range(0, DEPTH - 1);
		case ($urandom_range(0, 7))
			0:       v = '0;
			1:       v = '1;
			2, 3:    v = $urandom_range(0, 3);
			default: v = $urandom;
		endcase
		case ($urandom_range(0, 9))
			0:       l = $urandom_range(DEPTH + 1, 31);
			1:       l = DEPTH;
			default: l = $urandom_range(0, 8);
		endcase
		if (sel < 15) begin
			m = MODE_READ;
			if ($urandom_range(0, 9) == 0) begin
				p = $urandom_range(DEPTH, 31);
			end else if (!table_written[p]) begin
				// Steer the read onto an entry that holds a written word.
				k = 0;
				while (k < DEPTH && !table_written[(p + k) % DEPTH])
					k++;
				if (k == DEPTH)
					m = MODE_WRITE;
				else
					p = (p + k) % DEPTH;
			end
		end else if (sel < 30) begin
			m = MODE_WRITE;
			if ($urandom_range(0, 15) == 0)
				p = $urandom_range(DEPTH, 31);
		end else if (sel < 55) begin
			m = MODE_INSERT;
			p = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, live_count);
		end else if (sel < 75) begin
			m = MODE_SEARCH;
			// Search for a live word most of the time so hits are common.
			if (live_count > 0 && $urandom_range(0, 2) != 0)
				v = table_words[$urandom_range(0, live_count - 1)];
		end else if (sel < 85) begin
			m = MODE_RESIZE;
		end else if (sel < 92) begin
			m = MODE_FILL_VALUE;
		end else if (sel < 98) begin
			m = MODE_FILL_INDEX;
		end else begin
			m = MODE_UNUSED;
		end
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
			mismatches++;
		end
	endtask

	// Receiver: take results, compare them with the oldest pending one, and
	// stall for a random count of cycles after each. Once, hold off for a long
	// stretch so the block backs up and stalls its input.
	initial begin
		int      stall_left;
		int      results_seen;
		result_t want;
		out_stall    = 1'b0;
		stall_left   = 0;
		results_seen = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result with no item pending: expected none, got ok=%0b count=%0d",
						$time, ok, element_count);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("ok", want.ok, ok);
					check_field("found", want.found, found);
					check_field("found_index", want.found_index, found_index);
					check_field("read_value", want.read_value, read_value);
					check_field("element_count", want.element_count, element_count);
				end
				results_seen++;
				if ($urandom_range(0, 63) == 0)
					rx_quiet = !rx_quiet;
				if (results_seen == BACKLOG_AT)
					stall_left = BACKLOG_CYCLES;
				else
					stall_left = rx_quiet ? 0 : $urandom_range(0, 9);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_stall <= (stall_left > 0);
		end
	end

	// Sender and run control.
	initial begin
		stim_row_t   directed_rows [$];
		stim_row_t   row;
		logic [2:0]  m;
		logic [4:0]  p;
		logic [4:0]  l;
		logic [31:0] v;

		arst_n     = 1'b0;
		in_valid   = 1'b0;
		mode       = MODE_READ;
		position   = '0;
		value      = '0;
		length     = '0;
		mismatches = 0;
		tx_quiet   = 1'b0;
		rx_quiet   = 1'b0;
		live_count = 0;
		for (int i = 0; i < DEPTH; i++) begin
			table_words[i]   = '0;
			table_written[i] = 1'b0;
		end

		// Empty table: search misses, everything out of range is refused.
		directed_rows = {directed_rows, op_row_exp(MODE_SEARCH, 0, 32'h0, 0, 1, 0, 0, 0, 0)};
		directed_rows = {directed_rows, op_row_exp(MODE_INSERT, 1, 32'h5, 0, 0, 0, 0, 0, 0)};
		directed_rows = {directed_rows, op_row_exp(MODE_READ, 16, 32'h0, 0, 0, 0, 0, 0, 0)};
		directed_rows = {directed_rows,
			op_row_exp(MODE_WRITE, 31, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0)};
		directed_rows = {directed_rows, op_row_exp(MODE_UNUSED, 0, 32'h0, 31, 0, 0, 0, 0, 0)};
		directed_rows = {directed_rows, op_row_exp(MODE_RESIZE, 0, 32'h0, 17, 0, 0, 0, 0, 0)};
		directed_rows = {directed_rows,
			op_row_exp(MODE_FILL_VALUE, 0, 32'h0, 31, 0, 0, 0, 0, 0)};
		// Full table: fill to capacity, read the top entry, insert is refused, search hits at 0.
		directed_rows = {directed_rows, op_row_exp(MODE_FILL_VALUE, 0, 32'hFFFF_FFFF, 16,
			1, 0, 0, 0, 16)};
		directed_rows = {directed_rows, op_row_exp(MODE_READ, 15, 32'h0, 0,
			1, 0, 0, 32'hFFFF_FFFF, 16)};
		directed_rows = {directed_rows, op_row_exp(MODE_INSERT, 0, 32'h1, 0, 0, 0, 0, 0, 16)};
		directed_rows = {directed_rows,
			op_row_exp(MODE_SEARCH, 0, 32'hFFFF_FFFF, 0, 1, 1, 0, 0, 16)};
		// Index fill: each entry holds its own index; then search, read, and shrink to empty.
		directed_rows = {directed_rows,
			op_row_exp(MODE_FILL_INDEX, 0, 32'h0, 16, 1, 0, 0, 0, 16)};
		directed_rows = {directed_rows,
			op_row_exp(MODE_SEARCH, 0, 32'd15, 0, 1, 1, 15, 0, 16)};
		directed_rows = {directed_rows, op_row_exp(MODE_READ, 7, 32'h0, 0, 1, 0, 0, 32'd7, 16)};
		directed_rows = {directed_rows, op_row_exp(MODE_RESIZE, 0, 32'h0, 0, 1, 0, 0, 0, 0)};
		// Append, append at the count, insert at the front with a shift, then search hit and miss.
		directed_rows = {directed_rows, op_row_exp(MODE_INSERT, 0, 32'h0, 0, 1, 0, 0, 0, 1)};
		directed_rows = {directed_rows, op_row(MODE_INSERT, 1, 32'hA5A5_A5A5, 0)};
		directed_rows = {directed_rows, op_row(MODE_INSERT, 0, 32'h5A5A_5A5A, 0)};
		directed_rows = {directed_rows, op_row(MODE_SEARCH, 0, 32'hA5A5_A5A5, 0)};
		directed_rows = {directed_rows, op_row(MODE_SEARCH, 0, 32'h1234_5678, 0)};
		// Grow with zero fill, read a zeroed entry, touch an entry past the count, fill zero.
		directed_rows = {directed_rows, op_row(MODE_RESIZE, 0, 32'h0, 5)};
		directed_rows = {directed_rows, op_row(MODE_READ, 4, 32'h0, 0)};
		directed_rows = {directed_rows, op_row(MODE_WRITE, 15, 32'h8000_0000, 0)};
		directed_rows = {directed_rows, op_row(MODE_READ, 15, 32'h0, 0)};
		directed_rows = {directed_rows, op_row(MODE_FILL_VALUE, 0, 32'h0, 0)};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_item(row.op, row.pos, row.word, row.len, row.typed, row.want);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick_random_item(m, p, v, l);
			send_item(m, p, v, l, 1'b0, '0);
		end
		in_valid <= 1'b0;

		// Drain: wait for every pending result, then watch for strays.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
